// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property, clocked by clk_i, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert a property that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ----- rtl/core/tli_pkg.sv -----
// package of the track linear interpolator: types, codes, sizes
package tli_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] point_time;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [1:0]         status;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE    = 4'd0,
    CMD_LOAD    = 4'd1,  // latch input beat, reset scan index
    CMD_SCAN    = 4'd2,  // issue read at scan index
    CMD_CHECK   = 4'd3,  // compare read key, advance index if below
    CMD_OVERWR  = 4'd4,  // write coords at scan index
    CMD_SHRD    = 4'd5,  // read entry at shift index - 1
    CMD_SHWR    = 4'd6,  // write it at shift index, step down
    CMD_PUT     = 4'd7,  // write new point at insert index
    CMD_RDLO    = 4'd8,  // read entry at lower neighbor
    CMD_RDHI    = 4'd9,  // latch lower, read upper
    CMD_LATHI   = 4'd10, // latch upper entry
    CMD_DIVSTEP = 4'd11, // one quotient bit
    CMD_MUL     = 4'd12, // blend one coordinate
    CMD_CLEAR   = 4'd13
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] mul_sel;
  } ctl_t;

  typedef struct packed {
    logic       key_less;   // read key below query time
    logic       key_equal;
    logic       scan_end;   // scan index reached entry count
    logic       full;
    logic       empty;
    logic       shift_done; // shift index equals insert index
    logic       div_done;
    logic       idx_zero;
    op_e        op;
  } stat_t;
endpackage

// ----- rtl/core/track_linear_interpolator.sv -----
// top level of the track linear interpolator
// one item at a time; an insert scans for its key, then overwrites it or shifts the entries
// above it up; a query between keys runs the scan, a 16 step divider and 3 multiplies
// result held in an output register until taken; next item accepted after that
// reset clears the entry count and the controller; point memories keep contents
module track_linear_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tli_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tli_pkg::out_item_t  out_item_o
);
  import tli_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic [31:0] px, py, pz;
  logic [31:0] rd_x, rd_y, rd_z;

  tli_datapath u_dp (
    .clk_i, .rst_ni, .in_item_i, .ctl_i(ctl), .stat_o(stat),
    .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz),
    .rd_x_o(rd_x), .rd_y_o(rd_y), .rd_z_o(rd_z)
  );

  tli_controller u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz),
    .rd_x_i(rd_x), .rd_y_i(rd_y), .rd_z_i(rd_z),
    .ctl_o(ctl), .out_item_o
  );
endmodule

// ----- rtl/core/tli_datapath.sv -----
// datapath: point memories, scan index, divider and blend multiplier
module tli_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tli_pkg::in_item_t in_item_i,
  input  tli_pkg::ctl_t     ctl_i,
  output tli_pkg::stat_t    stat_o,
  output logic [31:0]       pos_x_o,
  output logic [31:0]       pos_y_o,
  output logic [31:0]       pos_z_o,
  output logic [31:0]       rd_x_o,
  output logic [31:0]       rd_y_o,
  output logic [31:0]       rd_z_o
);
  import tli_pkg::*;

  // point memories, one write port and one registered read
  logic [127:0] mem_q [TableDepth];
  logic [127:0] rd_q;

  in_item_t       item_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] sh_q, sh_d;
  logic [127:0]   lo_q, hi_q;
  logic [32:0]    rem_q, rem_d;
  logic [32:0]    den_q, den_d;
  logic [15:0]    quo_q, quo_d;
  logic [4:0]     dcnt_q, dcnt_d;
  logic [31:0]    px_q, py_q, pz_q;

  logic [IdxW-1:0] wr_addr, rd_addr;
  logic           wr_en;
  logic [127:0]   wr_data;
  logic           rd_en;

  // address and write selection
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx_q[IdxW-1:0];
    wr_data = {item_q.point_time, item_q.coord_x, item_q.coord_y, item_q.coord_z};
    rd_en = 1'b0;
    rd_addr = idx_q[IdxW-1:0];
    case (ctl_i.cmd)
      CMD_SCAN: rd_en = 1'b1;
      CMD_OVERWR, CMD_PUT: wr_en = 1'b1;
      CMD_SHRD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(sh_q - CntW'(1));
      end
      CMD_SHWR: begin
        wr_en = 1'b1;
        wr_addr = sh_q[IdxW-1:0];
        wr_data = rd_q;
      end
      CMD_RDLO: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(idx_q - CntW'(1));
      end
      CMD_RDHI: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // blend of one coordinate: biased unsigned mac, one product per term
  logic [31:0] a_sel, b_sel;
  logic [16:0] w1;
  logic [48:0] acc;
  always_comb begin
    case (ctl_i.mul_sel)
      2'd0: begin a_sel = lo_q[95:64]; b_sel = hi_q[95:64]; end
      2'd1: begin a_sel = lo_q[63:32]; b_sel = hi_q[63:32]; end
      default: begin a_sel = lo_q[31:0]; b_sel = hi_q[31:0]; end
    endcase
    w1 = 17'd65536 - {1'b0, quo_q};
    acc = 49'({~a_sel[31], a_sel[30:0]}) * 49'(w1)
        + 49'({~b_sel[31], b_sel[30:0]}) * 49'(quo_q);
  end
  logic [31:0] blend_r;
  assign blend_r = {~acc[47], acc[46:16]};

  // divider subtract step
  logic [33:0] trial;
  assign trial = {rem_q, 1'b0} - {1'b0, den_q};

  // control registers
  always_comb begin
    count_d = count_q;
    idx_d = idx_q;
    sh_d = sh_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    case (ctl_i.cmd)
      CMD_LOAD: idx_d = '0;
      CMD_CHECK: if (stat_o.key_less) idx_d = idx_q + CntW'(1);
      CMD_SHWR: sh_d = sh_q - CntW'(1);
      CMD_PUT: count_d = count_q + CntW'(1);
      CMD_CLEAR: count_d = '0;
      CMD_LATHI: begin
        rem_d = 33'($signed(item_q.point_time)) - 33'($signed(lo_q[127:96]));
        den_d = 33'($signed(rd_q[127:96])) - 33'($signed(lo_q[127:96]));
        quo_d = '0;
        dcnt_d = 5'd16;
      end
      CMD_DIVSTEP: begin
        if (!trial[33]) begin
          rem_d = trial[32:0];
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], 1'b0};
          quo_d = {quo_q[14:0], 1'b0};
        end
        dcnt_d = dcnt_q - 5'd1;
      end
      default: ;
    endcase
    if (ctl_i.cmd == CMD_CHECK || ctl_i.cmd == CMD_LOAD) sh_d = count_q;
  end

  // first step starts from num, so the numerator is shifted in place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q <= '0;
      sh_q <= '0;
      dcnt_q <= '0;
    end else begin
      count_q <= count_d;
      idx_q <= idx_d;
      sh_q <= sh_d;
      dcnt_q <= dcnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    if (ctl_i.cmd == CMD_LOAD) item_q <= in_item_i;
    if (ctl_i.cmd == CMD_RDHI) lo_q <= rd_q;
    if (ctl_i.cmd == CMD_LATHI) hi_q <= rd_q;
    if (ctl_i.cmd == CMD_CHECK) lo_q <= rd_q;
    if (ctl_i.cmd == CMD_MUL) begin
      case (ctl_i.mul_sel)
        2'd0: px_q <= blend_r;
        2'd1: py_q <= blend_r;
        default: pz_q <= blend_r;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.key_less = $signed(rd_q[127:96]) < $signed(item_q.point_time);
    stat_o.key_equal = rd_q[127:96] == item_q.point_time;
    stat_o.scan_end = idx_q == count_q;
    stat_o.full = count_q == CntW'(TableDepth);
    stat_o.empty = count_q == '0;
    stat_o.shift_done = sh_q == idx_q;
    stat_o.div_done = dcnt_q == 5'd0;
    stat_o.idx_zero = idx_q == '0;
    stat_o.op = op_e'(item_q.op);
  end

  // quotient stays below 2^16 since num < den
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign pos_z_o = pz_q;

  // coordinates of the entry last read
  assign rd_x_o = rd_q[95:64];
  assign rd_y_o = rd_q[63:32];
  assign rd_z_o = rd_q[31:0];
endmodule

// ----- rtl/core/tli_controller.sv -----
// controller: sequences scan, shift, divide and blend, owns both handshakes
module tli_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tli_pkg::stat_t       stat_i,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          pos_z_i,
  input  logic [31:0]          rd_x_i,
  input  logic [31:0]          rd_y_i,
  input  logic [31:0]          rd_z_i,
  output tli_pkg::ctl_t        ctl_o,
  output tli_pkg::out_item_t   out_item_o
);
  import tli_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_SCAN  = 14'b00000000000100,
    S_CHECK = 14'b00000000001000,
    S_SHRD  = 14'b00000000010000,
    S_SHWR  = 14'b00000000100000,
    S_RDLO  = 14'b00000001000000,
    S_RDHI  = 14'b00000010000000,
    S_LATHI = 14'b00000100000000,
    S_DIV   = 14'b00001000000000,
    S_MUL   = 14'b00010000000000,
    S_MULW  = 14'b00100000000000,
    S_RDK   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] msel_q, msel_d;
  out_item_t res_q, res_d;
  logic ovalid_q, ovalid_d;

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_item_o = res_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    msel_d = msel_q;
    res_d = res_q;
    ovalid_d = ovalid_q;
    ctl_o.cmd = CMD_IDLE;
    ctl_o.mul_sel = msel_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        ctl_o.cmd = CMD_LOAD;
        state_d = S_DISP;
      end
      S_DISP: begin
        res_d = '0;
        case (stat_i.op)
          OP_CLEAR: begin
            ctl_o.cmd = CMD_CLEAR;
            state_d = S_DONE;
          end
          OP_NONE: state_d = S_DONE;
          OP_QUERY: if (stat_i.empty) begin
            res_d.status = ST_EMPTY;
            state_d = S_DONE;
          end else state_d = S_SCAN;
          default: state_d = S_SCAN;
        endcase
      end
      S_SCAN: if (stat_i.scan_end) begin
        // no key at or above the time
        if (stat_i.op == OP_QUERY) begin
          state_d = S_RDLO;
        end else if (stat_i.full) begin
          res_d.status = ST_FULL;
          state_d = S_DONE;
        end else state_d = S_SHRD;
      end else begin
        ctl_o.cmd = CMD_SCAN;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        ctl_o.cmd = CMD_CHECK;
        if (stat_i.key_less) state_d = S_SCAN;
        else if (stat_i.op == OP_QUERY) begin
          if (stat_i.key_equal || stat_i.idx_zero) begin
            res_d.pos_x = rd_x_i;
            res_d.pos_y = rd_y_i;
            res_d.pos_z = rd_z_i;
            state_d = S_DONE;
          end else state_d = S_RDLO;
        end else if (stat_i.key_equal) begin
          state_d = S_RDK;
        end else if (stat_i.full) begin
          res_d.status = ST_FULL;
          state_d = S_DONE;
        end else state_d = S_SHRD;
      end
      S_RDK: begin
        ctl_o.cmd = CMD_OVERWR;
        state_d = S_DONE;
      end
      S_SHRD: if (stat_i.shift_done) begin
        ctl_o.cmd = CMD_PUT;
        state_d = S_DONE;
      end else begin
        ctl_o.cmd = CMD_SHRD;
        state_d = S_SHWR;
      end
      S_SHWR: begin
        ctl_o.cmd = CMD_SHWR;
        state_d = S_SHRD;
      end
      S_RDLO: begin
        ctl_o.cmd = CMD_RDLO;
        state_d = stat_i.scan_end ? S_MULW : S_RDHI;
      end
      S_MULW: begin
        // past the last key: the read entry is the answer
        res_d.pos_x = rd_x_i;
        res_d.pos_y = rd_y_i;
        res_d.pos_z = rd_z_i;
        state_d = S_DONE;
      end
      S_RDHI: begin
        ctl_o.cmd = CMD_RDHI;
        state_d = S_LATHI;
      end
      S_LATHI: begin
        ctl_o.cmd = CMD_LATHI;
        state_d = S_DIV;
      end
      S_DIV: if (stat_i.div_done) begin
        msel_d = 2'd0;
        state_d = S_MUL;
      end else ctl_o.cmd = CMD_DIVSTEP;
      S_MUL: begin
        // three multiplies, then all three results are picked up into the result register
        if (msel_q == 2'd3) begin
          res_d.status = ST_OK;
          res_d.pos_x = pos_x_i;
          res_d.pos_y = pos_y_i;
          res_d.pos_z = pos_z_i;
          state_d = S_DONE;
        end else begin
          ctl_o.cmd = CMD_MUL;
          msel_d = msel_q + 2'd1;
        end
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      msel_q <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      msel_q <= msel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // results of the blend land in the cycle after the last multiply
  `ASSERT_CLK(a_no_accept_busy, in_valid_i && in_ready_o |-> !out_valid_o, "accept while busy")
  `ASSERT_CLK(a_onehot, $onehot(state_q), "state not one-hot")
  `ASSERT_CLK(a_done_valid, state_q == S_DONE |=> out_valid_o, "result not shown")
endmodule

// ----- sim/tb_top.sv -----
// testbench of the track linear interpolator: table of directed beats, random beats, predictor
`timescale 1ns / 1ps
module tb_top;
  import tli_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  track_linear_interpolator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the point table
  logic signed [31:0] trk_key [TableDepth];
  logic signed [31:0] trk_x [TableDepth];
  logic signed [31:0] trk_y [TableDepth];
  logic signed [31:0] trk_z [TableDepth];
  int unsigned        trk_count = 0;

  out_item_t   pending_pos [$];
  int unsigned err_count = 0;
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  bit          stim_done = 1'b0;
  bit          hold_long = 1'b0;
  longint      cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, got_count, got, want);
    err_count++;
  endtask

  function automatic int unsigned search_pos(input logic signed [31:0] t);
    int unsigned i;
    i = 0;
    while (i < trk_count && trk_key[i] < t) i++;
    return i;
  endfunction

  function automatic logic signed [31:0] mix_coord(input logic signed [31:0] a,
      input logic signed [31:0] b, input logic [16:0] w);
    logic signed [64:0] acc;
    acc = 65'(a) * $signed({1'b0, 17'd65536 - w}) + 65'(b) * $signed({1'b0, w});
    return acc[47:16];
  endfunction

  function automatic out_item_t predict_pos(input in_item_t it);
    out_item_t r;
    int unsigned i;
    logic signed [32:0] num, den;
    logic [48:0] q;
    logic [16:0] w;
    r = '0;
    r.status = ST_OK;
    case (op_e'(it.op))
      OP_INSERT: begin
        i = search_pos(it.point_time);
        if (i < trk_count && trk_key[i] == it.point_time) begin
          trk_x[i] = it.coord_x; trk_y[i] = it.coord_y; trk_z[i] = it.coord_z;
        end else if (trk_count >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          for (int j = trk_count; j > i; j--) begin
            trk_key[j] = trk_key[j-1]; trk_x[j] = trk_x[j-1];
            trk_y[j] = trk_y[j-1]; trk_z[j] = trk_z[j-1];
          end
          trk_key[i] = it.point_time;
          trk_x[i] = it.coord_x; trk_y[i] = it.coord_y; trk_z[i] = it.coord_z;
          trk_count++;
        end
      end
      OP_QUERY: begin
        if (trk_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          i = search_pos(it.point_time);
          if (i >= trk_count) i = trk_count - 1;
          if (i == 0 || trk_key[i] == it.point_time || i == search_pos(it.point_time)
              && 0) begin
            r.pos_x = trk_x[i]; r.pos_y = trk_y[i]; r.pos_z = trk_z[i];
          end else if (search_pos(it.point_time) >= trk_count) begin
            r.pos_x = trk_x[i]; r.pos_y = trk_y[i]; r.pos_z = trk_z[i];
          end else begin
            // strictly between two keys
            num = 33'(it.point_time) - 33'(trk_key[i-1]);
            den = 33'(trk_key[i]) - 33'(trk_key[i-1]);
            q = {16'(0), num} << 16;
            q = q / 49'(den);
            w = (q > 49'd65535) ? 17'd65535 : q[16:0];
            r.pos_x = mix_coord(trk_x[i-1], trk_x[i], w);
            r.pos_y = mix_coord(trk_y[i-1], trk_y[i], w);
            r.pos_z = mix_coord(trk_z[i-1], trk_z[i], w);
          end
        end
      end
      OP_CLEAR: trk_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  // valid stays high across back to back beats, drops only for a gap
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pos = {pending_pos, predict_pos(it)};
    sent_count++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 400)) - 200;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_beat(input int unsigned span);
    in_item_t it;
    int unsigned p;
    it.coord_x = rand_word(); it.coord_y = rand_word(); it.coord_z = rand_word();
    p = $urandom_range(0, 99);
    if (p < 45) it.op = OP_INSERT;
    else if (p < 93) it.op = OP_QUERY;
    else if (p < 97) it.op = OP_CLEAR;
    else it.op = OP_NONE;
    // mostly a narrow time span so keys collide and queries land between points
    if ($urandom_range(0, 4) == 0) it.point_time = rand_word();
    else it.point_time = $signed($urandom_range(0, span)) - $signed(span / 2);
    return it;
  endfunction

  // directed rows: op, time, x, y, z, check flag, expected result
  typedef struct {
    op_e               op;
    logic signed [31:0] t, x, y, z;
    bit                fixed;
    out_item_t         want;
  } row_t;

  row_t dir_rows [] = '{
    '{OP_QUERY, 0, 0, 0, 0, 1, '{0, 0, 0, ST_EMPTY}},
    '{OP_CLEAR, 0, 0, 0, 0, 1, '{0, 0, 0, ST_OK}},
    '{OP_NONE, 32'sh7fffffff, -1, -1, -1, 1, '{0, 0, 0, ST_OK}},
    '{OP_INSERT, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 1, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 32'sh80000000, 0, 0, 0, 1, '{32'sh7fffffff, 32'sh80000000, 0, ST_OK}},
    '{OP_QUERY, 32'sh7fffffff, 0, 0, 0, 1, '{32'sh7fffffff, 32'sh80000000, 0, ST_OK}},
    '{OP_INSERT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 1, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 0, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, -1, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 32'sh7ffffffe, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_INSERT, 0, 100, 200, 300, 1, '{0, 0, 0, ST_OK}},
    '{OP_INSERT, 0, 7, 8, 9, 1, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 0, 0, 0, 0, 1, '{7, 8, 9, ST_OK}},
    '{OP_QUERY, 1, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_CLEAR, 0, 0, 0, 0, 1, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 5, 0, 0, 0, 1, '{0, 0, 0, ST_EMPTY}},
    '{OP_INSERT, 10, -65536, 65536, 3, 1, '{0, 0, 0, ST_OK}},
    '{OP_INSERT, 20, 65536, -65536, -3, 1, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 15, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 19, 0, 0, 0, 0, '{0, 0, 0, ST_OK}},
    '{OP_QUERY, 9, 0, 0, 0, 1, '{-65536, 65536, 3, ST_OK}},
    '{OP_QUERY, 21, 0, 0, 0, 1, '{65536, -65536, -3, ST_OK}}
  };

  // stimulus
  initial begin
    in_item_t it;
    out_item_t pred;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) begin
      it = '{dir_rows[k].op, dir_rows[k].t, dir_rows[k].x, dir_rows[k].y, dir_rows[k].z};
      send_beat(it);
      if (dir_rows[k].fixed) begin
        pred = pending_pos[$];
        if (pred != dir_rows[k].want) report_mismatch("directed row", k, 0);
      end
    end
    // fill to full, then one more new key, an overwrite of an existing one and two queries
    it = '{OP_CLEAR, 0, 0, 0, 0};
    send_beat(it);
    for (int k = 0; k < TableDepth; k++) begin
      it = '{OP_INSERT, 32'(k * 1000), rand_word(), rand_word(), rand_word()};
      send_beat(it);
    end
    it = '{OP_INSERT, 500, 1, 2, 3};
    send_beat(it);
    if (pending_pos[$].status != ST_FULL) report_mismatch("full status", 0, ST_FULL);
    it = '{OP_INSERT, 2000, 4, 5, 6};
    send_beat(it);
    it = '{OP_QUERY, 2000, 0, 0, 0};
    send_beat(it);
    it = '{OP_QUERY, 63500, 0, 0, 0};
    send_beat(it);
    // the receiver drops the flag once its hold-off is over
    hold_long = 1'b1;
    for (int k = 0; k < 10; k++) send_beat(rand_beat(4000));
    // random part; the span varies so the table both fills and stays sparse
    for (int k = 0; k < 1050; k++) begin
      send_beat(rand_beat((k / 200) % 2 ? 200 : 1 << $urandom_range(8, 30)));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) stall = 0;
      out_ready_i <= (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pos.size() == 0) begin
        report_mismatch("unexpected beat", out_item_o.status, 0);
      end else begin
        w = pending_pos.pop_front();
        if (out_item_o.pos_x !== w.pos_x) report_mismatch("pos_x", out_item_o.pos_x, w.pos_x);
        if (out_item_o.pos_y !== w.pos_y) report_mismatch("pos_y", out_item_o.pos_y, w.pos_y);
        if (out_item_o.pos_z !== w.pos_z) report_mismatch("pos_z", out_item_o.pos_z, w.pos_z);
        if (out_item_o.status !== w.status)
          report_mismatch("status", out_item_o.status, w.status);
      end
      got_count++;
    end
  end

  // end of run and watchdog
  initial begin
    fork
      begin
        wait (stim_done && pending_pos.size() == 0);
        repeat (300) @(posedge clk_i);
        if (err_count == 0 && pending_pos.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
      end
      begin
        while (cycle_count < 1500000) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
      end
    join_any
    $finish;
  end
endmodule
